[rtl/lao_pkg.sv]
// lao_pkg: shared types, codes and constants of the logo alpha overlay block
// holds item, result, configuration and queue entry types plus the divide-by-255 helper
// no dependencies
package lao_pkg;

	// default sizes of the logo store and coordinate width
	localparam int LOGO_MAX_W_DEF = 256;
	localparam int LOGO_MAX_H_DEF = 256;
	localparam int COORD_BITS_DEF = 12;

	// fixed field widths
	localparam int COORD_W     = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	// depth of the decoupling and result queues
	localparam int QUEUE_DEPTH = 4;

	// item command codes
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	// logo channel modes, code 3 leaves covered pixels unchanged
	typedef enum logic [1:0] {
		MODE_GRAY  = 2'd0,
		MODE_BGR   = 2'd1,
		MODE_BLEND = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POS_X         = 3'd0,
		REG_POS_Y         = 3'd1,
		REG_LOGO_WIDTH    = 3'd2,
		REG_LOGO_HEIGHT   = 3'd3,
		REG_BOX_WIDTH     = 3'd4,
		REG_BOX_HEIGHT    = 3'd5,
		REG_CENTER_ENABLE = 3'd6,
		REG_CHANNEL_MODE  = 3'd7
	} reg_idx_t;

	// input transaction
	typedef struct packed {
		cmd_t              cmd;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [7:0]        in_blue;
		logic [7:0]        in_green;
		logic [7:0]        in_red;
		logic [7:0]        in_alpha;
	} item_t;

	// result transaction
	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       covered;
	} result_t;

	// configuration register set
	typedef struct packed {
		logic [12:0] pos_x;
		logic [12:0] pos_y;
		logic [8:0]  logo_width;
		logic [8:0]  logo_height;
		logic [11:0] box_width;
		logic [11:0] box_height;
		logic        center_enable;
		mode_t       channel_mode;
	} cfg_t;

	// store word and color bytes: bgr[0] blue, bgr[1] green, bgr[2] red
	typedef struct packed {
		logic [7:0]      alpha;
		logic [2:0][7:0] bgr;
	} color_t;

	// control part of a queue entry between front and back
	typedef struct packed {
		cmd_t op;
		logic covered;
	} ctl_t;

	// exact floor(x / 255) for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

[rtl/lao_fifo.sv]
// lao_fifo: small register queue with full and empty flags
// used between front and back and as the result queue; depends on lao_pkg
module lao_fifo import lao_pkg::*; #(
	parameter int DATA_W = 1,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	// flags and handshakes
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/lao_front.sv]
// lao_front: accepts transactions, places the logo and classifies each item
// produces store address, coverage and color for the back part; depends on lao_pkg
module lao_front import lao_pkg::*; #(
	parameter int LOGO_MAX_W = LOGO_MAX_W_DEF,
	parameter int LOGO_MAX_H = LOGO_MAX_H_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ADDR_W     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              push,
	input  item_t             item,
	output logic              full,
	output logic              q_wr,
	output ctl_t              q_ctl,
	output logic [ADDR_W-1:0] q_addr,
	output color_t            q_color,
	input  logic              q_full
);

	// logo size saturates at the store size, and never exceeds the 9-bit field
	localparam int LW_CAP = (LOGO_MAX_W > 511) ? 511 : LOGO_MAX_W;
	localparam int LH_CAP = (LOGO_MAX_H > 511) ? 511 : LOGO_MAX_H;

	logic [8:0]         lw;
	logic [8:0]         lh;
	logic [11:0]        slack_x;
	logic [11:0]        slack_y;
	logic [13:0]        px;
	logic [13:0]        py;
	logic [8:0]         lw_q;
	logic [8:0]         lh_q;
	logic [13:0]        px_q;
	logic [13:0]        py_q;

	logic               v_s1;
	item_t              item_s1;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [14:0]        col_c;
	logic [14:0]        row_c;

	logic               v_s2;
	cmd_t               cmd_s2;
	logic [14:0]        col_s2;
	logic [14:0]        row_s2;
	color_t             color_s2;

	logic               in_store;
	logic               covered;
	logic               keep_s2;
	logic               rdy_s1;
	logic               rdy_s2;
	logic               accept;
	logic [ADDR_W-1:0]  row_a;
	logic [ADDR_W-1:0]  col_a;

	// logo origin from configuration, centered where enabled and the box exceeds the logo
	always_comb begin
		lw      = (cfg.logo_width > 9'(LW_CAP)) ? 9'(LW_CAP) : cfg.logo_width;
		lh      = (cfg.logo_height > 9'(LH_CAP)) ? 9'(LH_CAP) : cfg.logo_height;
		slack_x = cfg.box_width - {3'b0, lw};
		slack_y = cfg.box_height - {3'b0, lh};
		px      = {cfg.pos_x[12], cfg.pos_x};
		py      = {cfg.pos_y[12], cfg.pos_y};
		if (cfg.center_enable && (cfg.box_width > {3'b0, lw})) begin
			px = px + {3'b0, slack_x[11:1]};
		end
		if (cfg.center_enable && (cfg.box_height > {3'b0, lh})) begin
			py = py + {3'b0, slack_y[11:1]};
		end
	end

	// placement registers follow the configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= '0;
			lh_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else begin
			lw_q <= lw;
			lh_q <= lh;
			px_q <= px;
			py_q <= py;
		end
	end

	// pipeline handshakes
	assign keep_s2 = (cmd_s2 == CMD_LOAD) ? in_store : 1'b1;
	assign rdy_s2  = !v_s2 || !keep_s2 || !q_full;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign full    = !rdy_s1;
	assign accept  = push && rdy_s1;

	// stage 1: mask coordinates and, for pixels, take them relative to the logo origin
	always_comb begin
		for (int i = 0; i < COORD_W; i++) begin
			cx[i] = item_s1.coord_x[i] & (i < COORD_BITS);
			cy[i] = item_s1.coord_y[i] & (i < COORD_BITS);
		end
		if (item_s1.cmd == CMD_LOAD) begin
			col_c = {3'b0, cx};
			row_c = {3'b0, cy};
		end else begin
			col_c = {3'b0, cx} - {px_q[13], px_q};
			row_c = {3'b0, cy} - {py_q[13], py_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (rdy_s2 && v_s1) begin
			cmd_s2         <= item_s1.cmd;
			col_s2         <= col_c;
			row_s2         <= row_c;
			color_s2.alpha <= item_s1.in_alpha;
			color_s2.bgr   <= {item_s1.in_red, item_s1.in_green, item_s1.in_blue};
		end
	end

	// stage 2: range checks and store address
	always_comb begin
		in_store = !col_s2[14] && (col_s2 < 15'(LOGO_MAX_W))
			&& !row_s2[14] && (row_s2 < 15'(LOGO_MAX_H));
		covered  = (cmd_s2 == CMD_PIXEL)
			&& !col_s2[14] && (col_s2 < {6'b0, lw_q})
			&& !row_s2[14] && (row_s2 < {6'b0, lh_q});
		row_a    = ADDR_W'(row_s2);
		col_a    = ADDR_W'(col_s2);
	end

	assign q_wr          = v_s2 && keep_s2 && !q_full;
	assign q_ctl.op      = cmd_s2;
	assign q_ctl.covered = covered;
	assign q_addr        = row_a * ADDR_W'(LOGO_MAX_W) + col_a;
	assign q_color       = color_s2;

	// a covered pixel needs a non-empty logo
	a_cov_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr && q_ctl.covered |-> (lw_q != '0) && (lh_q != '0))
		else $error("covered pixel with empty logo");

	// a blocked stage 2 keeps its entry
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s2 |=> v_s2 && $stable(col_s2) && $stable(row_s2))
		else $error("stage 2 entry lost while blocked");

endmodule

[rtl/lao_back.sv]
// lao_back: logo store, blend arithmetic and result queue
// carries out queued loads and pixels in order; depends on lao_pkg and lao_fifo
module lao_back import lao_pkg::*; #(
	parameter int LOGO_MAX_W = LOGO_MAX_W_DEF,
	parameter int LOGO_MAX_H = LOGO_MAX_H_DEF,
	parameter int ADDR_W     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mode_t             mode,
	input  logic              q_empty,
	output logic              q_rd,
	input  ctl_t              q_ctl,
	input  logic [ADDR_W-1:0] q_addr,
	input  color_t            q_color,
	output logic              empty,
	input  logic              pop,
	output result_t           result
);

	localparam int STORE_DEPTH = LOGO_MAX_W * LOGO_MAX_H;

	color_t           store_mem [STORE_DEPTH];

	logic             v_b1;
	logic             cov_b1;
	color_t           src_b1;
	logic [2:0][7:0]  dst_b1;

	logic             v_b2;
	logic             cov_b2;
	color_t           src_b2;
	logic [2:0][7:0]  dst_b2;
	logic [2:0][15:0] sum_b2;

	logic [2:0][15:0] sum_c;
	result_t          res_c;
	logic             rdy_b1;
	logic             rdy_b2;
	logic             out_wr;
	logic             out_full;

	// pipeline handshakes
	assign rdy_b2 = !v_b2 || !out_full;
	assign rdy_b1 = !v_b1 || rdy_b2;
	assign out_wr = v_b2 && !out_full;
	assign q_rd   = !q_empty && rdy_b1;

	// logo store: loads write, pixels read
	always_ff @(posedge clk) begin
		if (q_rd && (q_ctl.op == CMD_LOAD)) begin
			store_mem[q_addr] <= q_color;
		end
		if (q_rd && (q_ctl.op == CMD_PIXEL)) begin
			src_b1 <= store_mem[q_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
		end else begin
			if (rdy_b1) begin
				v_b1 <= q_rd && (q_ctl.op == CMD_PIXEL);
			end
			if (rdy_b2) begin
				v_b2 <= v_b1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cov_b1 <= q_ctl.covered;
			dst_b1 <= q_color.bgr;
		end
	end

	// weighted sums s*a + d*(255-a) per channel
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = 16'(src_b1.bgr[k]) * 16'(src_b1.alpha)
				+ 16'(dst_b1[k]) * 16'(8'd255 - src_b1.alpha);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_b2 && v_b1) begin
			cov_b2 <= cov_b1;
			src_b2 <= src_b1;
			dst_b2 <= dst_b1;
			sum_b2 <= sum_c;
		end
	end

	// stage 2: divide and choose by channel mode
	always_comb begin
		res_c.out_blue  = dst_b2[0];
		res_c.out_green = dst_b2[1];
		res_c.out_red   = dst_b2[2];
		res_c.covered   = cov_b2;
		if (cov_b2) begin
			case (mode)
				MODE_GRAY: begin
					res_c.out_blue  = src_b2.bgr[0];
					res_c.out_green = src_b2.bgr[0];
					res_c.out_red   = src_b2.bgr[0];
				end
				MODE_BGR: begin
					res_c.out_blue  = src_b2.bgr[0];
					res_c.out_green = src_b2.bgr[1];
					res_c.out_red   = src_b2.bgr[2];
				end
				MODE_BLEND: begin
					res_c.out_blue  = div255(sum_b2[0]);
					res_c.out_green = div255(sum_b2[1]);
					res_c.out_red   = div255(sum_b2[2]);
				end
				default: begin
				end
			endcase
		end
	end

	// result queue
	lao_fifo #(
		.DATA_W ($bits(result_t)),
		.DEPTH  (QUEUE_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (res_c),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	// store data held while stage 1 waits
	a_b1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_b1 && !rdy_b1 |=> v_b1 && $stable(src_b1) && $stable(dst_b1))
		else $error("store read data changed while stalled");

	// uncovered pixels pass the frame color
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_b2 && !cov_b2 |-> (res_c.out_blue == dst_b2[0]) && (res_c.out_green == dst_b2[1])
			&& (res_c.out_red == dst_b2[2]) && !res_c.covered)
		else $error("uncovered pixel altered");

endmodule

[rtl/logo_alpha_overlay_unit.sv]
// logo_alpha_overlay_unit: top level of the logo alpha overlay block
// holds the configuration registers and links front, queue and back; depends on lao_pkg,
// lao_fifo, lao_front and lao_back
//
//  channel   handshake            payload              transaction
//  input     push / full          item (item_t)        push && !full
//  result    empty / pop          result (result_t)    pop && !empty
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data  cfg_valid && cfg_ready
//
// one item per clock when nothing stalls; a frame pixel passes two front stages, the middle queue,
// the store read and blend stages and the result queue before it shows on the result side
// a load takes effect when it leaves the queue, ahead of any later pixel
// reset clears control state and configuration; the logo store is not cleared
// a full result queue stalls the back, a full middle queue stalls the front and raises full
module logo_alpha_overlay_unit import lao_pkg::*; #(
	parameter int LOGO_MAX_W = LOGO_MAX_W_DEF,
	parameter int LOGO_MAX_H = LOGO_MAX_H_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  item_t                  item,
	output logic                   full,
	output logic                   empty,
	input  logic                   pop,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = (LOGO_MAX_W * LOGO_MAX_H > 1) ? $clog2(LOGO_MAX_W * LOGO_MAX_H) : 1;
	localparam int MID_W  = $bits(ctl_t) + ADDR_W + $bits(color_t);

	cfg_t              cfg_q;
	logic              f_wr;
	ctl_t              f_ctl;
	logic [ADDR_W-1:0] f_addr;
	color_t            f_color;
	logic              mid_full;
	logic              mid_empty;
	logic              b_rd;
	logic [MID_W-1:0]  mid_wr_data;
	logic [MID_W-1:0]  mid_rd_data;
	ctl_t              b_ctl;
	logic [ADDR_W-1:0] b_addr;
	color_t            b_color;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= '0;
			cfg_q.pos_y         <= '0;
			cfg_q.logo_width    <= '0;
			cfg_q.logo_height   <= '0;
			cfg_q.box_width     <= '0;
			cfg_q.box_height    <= '0;
			cfg_q.center_enable <= 1'b0;
			cfg_q.channel_mode  <= MODE_BLEND;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_POS_X:         cfg_q.pos_x         <= cfg_data;
				REG_POS_Y:         cfg_q.pos_y         <= cfg_data;
				REG_LOGO_WIDTH:    cfg_q.logo_width    <= cfg_data[8:0];
				REG_LOGO_HEIGHT:   cfg_q.logo_height   <= cfg_data[8:0];
				REG_BOX_WIDTH:     cfg_q.box_width     <= cfg_data[11:0];
				REG_BOX_HEIGHT:    cfg_q.box_height    <= cfg_data[11:0];
				REG_CENTER_ENABLE: cfg_q.center_enable <= cfg_data[0];
				REG_CHANNEL_MODE:  cfg_q.channel_mode  <= mode_t'(cfg_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	lao_front #(
		.LOGO_MAX_W (LOGO_MAX_W),
		.LOGO_MAX_H (LOGO_MAX_H),
		.COORD_BITS (COORD_BITS),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.item    (item),
		.full    (full),
		.q_wr    (f_wr),
		.q_ctl   (f_ctl),
		.q_addr  (f_addr),
		.q_color (f_color),
		.q_full  (mid_full)
	);

	// queue between front and back
	assign mid_wr_data               = {f_ctl, f_addr, f_color};
	assign {b_ctl, b_addr, b_color}  = mid_rd_data;

	lao_fifo #(
		.DATA_W (MID_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_wr),
		.wr_data (mid_wr_data),
		.full    (mid_full),
		.rd_en   (b_rd),
		.rd_data (mid_rd_data),
		.empty   (mid_empty)
	);

	// back: store, blend and results
	lao_back #(
		.LOGO_MAX_W (LOGO_MAX_W),
		.LOGO_MAX_H (LOGO_MAX_H),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (cfg_q.channel_mode),
		.q_empty (mid_empty),
		.q_rd    (b_rd),
		.q_ctl   (b_ctl),
		.q_addr  (b_addr),
		.q_color (b_color),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[sim/tb_logo_alpha_overlay_unit.sv]
// tb_logo_alpha_overlay_unit: self-checking testbench of the logo alpha overlay block
// predicts each frame pixel from its own copy of the logo store and registers
// depends on lao_pkg and logo_alpha_overlay_unit
module tb_logo_alpha_overlay_unit;
	import lao_pkg::*;

	localparam int STORE_W       = LOGO_MAX_W_DEF;
	localparam int STORE_H       = LOGO_MAX_H_DEF;
	localparam int STORE_DEPTH   = STORE_W * STORE_H;
	localparam int COORD_MAX     = (1 << COORD_W) - 1;
	localparam int POS_MIN       = -4096;
	localparam int POS_MAX       = 4095;
	localparam int SIZE_FIELD_MAX = 511;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 85;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// block ports
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	item_t                  item      = '0;
	logic                   full;
	logic                   empty;
	logic                   pop       = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// register copy with reset values
	logic signed [12:0] cfg_pos_x  = '0;
	logic signed [12:0] cfg_pos_y  = '0;
	logic [8:0]         cfg_logo_w = '0;
	logic [8:0]         cfg_logo_h = '0;
	logic [11:0]        cfg_box_w  = '0;
	logic [11:0]        cfg_box_h  = '0;
	logic               cfg_center = 1'b0;
	logic [1:0]         cfg_mode   = MODE_BLEND;

	// logo store copy and which entries hold a written pixel
	logic [31:0] logo_words [STORE_DEPTH];
	bit          logo_loaded [STORE_DEPTH];

	result_t expected_pixels[$];
	int      error_count = 0;
	bit      steady_flow = 1'b0;

	logo_alpha_overlay_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// logo origin and clipped size, with centering in the box
	function automatic void place_logo(output int ox, output int oy, output int lw, output int lh);
		lw = (cfg_logo_w > STORE_W) ? STORE_W : int'(cfg_logo_w);
		lh = (cfg_logo_h > STORE_H) ? STORE_H : int'(cfg_logo_h);
		ox = int'(cfg_pos_x);
		oy = int'(cfg_pos_y);
		if (cfg_center) begin
			if (int'(cfg_box_w) > lw)
				ox += (int'(cfg_box_w) - lw) / 2;
			if (int'(cfg_box_h) > lh)
				oy += (int'(cfg_box_h) - lh) / 2;
		end
	endfunction

	function automatic logic [7:0] mix_channel(int s, int d, int a);
		return 8'((s * a + d * (255 - a)) / 255);
	endfunction

	// expected result of one frame pixel under the current registers
	function automatic result_t overlay_pixel(item_t it);
		result_t     res;
		int          ox, oy, lw, lh, lx, ly;
		logic [31:0] w;
		place_logo(ox, oy, lw, lh);
		lx = int'(it.coord_x) - ox;
		ly = int'(it.coord_y) - oy;
		res.out_blue  = it.in_blue;
		res.out_green = it.in_green;
		res.out_red   = it.in_red;
		res.covered   = 1'b0;
		if (lx >= 0 && lx < lw && ly >= 0 && ly < lh) begin
			w = logo_words[ly * STORE_W + lx];
			res.covered = 1'b1;
			case (cfg_mode)
				MODE_GRAY: begin
					res.out_blue  = w[7:0];
					res.out_green = w[7:0];
					res.out_red   = w[7:0];
				end
				MODE_BGR: begin
					res.out_blue  = w[7:0];
					res.out_green = w[15:8];
					res.out_red   = w[23:16];
				end
				MODE_BLEND: begin
					res.out_blue  = mix_channel(w[7:0], it.in_blue, w[31:24]);
					res.out_green = mix_channel(w[15:8], it.in_green, w[31:24]);
					res.out_red   = mix_channel(w[23:16], it.in_red, w[31:24]);
				end
				// unused mode keeps the frame color
				default: ;
			endcase
		end
		return res;
	endfunction

	// register update on an accepted write, upper data bits dropped
	function automatic void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_POS_X:         cfg_pos_x  = data[12:0];
			REG_POS_Y:         cfg_pos_y  = data[12:0];
			REG_LOGO_WIDTH:    cfg_logo_w = data[8:0];
			REG_LOGO_HEIGHT:   cfg_logo_h = data[8:0];
			REG_BOX_WIDTH:     cfg_box_w  = data[11:0];
			REG_BOX_HEIGHT:    cfg_box_h  = data[11:0];
			REG_CENTER_ENABLE: cfg_center = data[0];
			REG_CHANNEL_MODE:  cfg_mode   = data[1:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// coordinate in or near the logo span, kept inside the frame
	function automatic int rand_near(int org, int len);
		int v;
		v = org - 2 + int'($urandom_range(0, len + 3));
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(1, 12);
		if (r < 65)
			return 0;
		if (r < 80)
			return $urandom_range(13, 64);
		if (r < 90)
			return STORE_W;
		return $urandom_range(STORE_W + 1, SIZE_FIELD_MAX);
	endfunction

	function automatic int pick_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 60);
		if (r < 75)
			return POS_MIN;
		if (r < 80)
			return POS_MAX;
		return int'($urandom_range(0, POS_MAX - POS_MIN)) + POS_MIN;
	endfunction

	function automatic int pick_box();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 80);
		if (r < 60)
			return COORD_MAX;
		if (r < 70)
			return 0;
		return $urandom_range(0, COORD_MAX);
	endfunction

	// one register write transaction
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all registers, junk in the unused data bits
	task automatic set_config(input int px, input int py, input int lw, input int lh,
			input int bw, input int bh, input bit ce, input logic [1:0] mode);
		write_reg(REG_POS_X, 13'(px));
		write_reg(REG_POS_Y, 13'(py));
		write_reg(REG_LOGO_WIDTH, {4'($urandom), 9'(lw)});
		write_reg(REG_LOGO_HEIGHT, {4'($urandom), 9'(lh)});
		write_reg(REG_BOX_WIDTH, {1'($urandom), 12'(bw)});
		write_reg(REG_BOX_HEIGHT, {1'($urandom), 12'(bh)});
		write_reg(REG_CENTER_ENABLE, {12'($urandom), ce});
		write_reg(REG_CHANNEL_MODE, {11'($urandom), mode});
	endtask

	// one input transaction; push stays high for a following item without a gap
	task automatic send_item(input item_t it);
		int gap;
		int idx;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		if (it.cmd == CMD_PIXEL) begin
			expected_pixels.push_back(overlay_pixel(it));
		end else if (it.coord_x < STORE_W && it.coord_y < STORE_H) begin
			idx = int'(it.coord_y) * STORE_W + int'(it.coord_x);
			logo_words[idx]  = {it.in_alpha, it.in_red, it.in_green, it.in_blue};
			logo_loaded[idx] = 1'b1;
		end
	endtask

	task automatic send_load(input int x, input int y, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] a);
		item_t it;
		it.cmd      = CMD_LOAD;
		it.coord_x  = COORD_W'(x);
		it.coord_y  = COORD_W'(y);
		it.in_blue  = b;
		it.in_green = g;
		it.in_red   = r;
		it.in_alpha = a;
		send_item(it);
	endtask

	// frame pixel; a covered logo entry never written gets a load first
	task automatic send_pixel(input int x, input int y, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		item_t it;
		int    ox, oy, lw, lh, lx, ly;
		place_logo(ox, oy, lw, lh);
		lx = x - ox;
		ly = y - oy;
		if (lx >= 0 && lx < lw && ly >= 0 && ly < lh && !logo_loaded[ly * STORE_W + lx])
			send_load(lx, ly, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		it.cmd      = CMD_PIXEL;
		it.coord_x  = COORD_W'(x);
		it.coord_y  = COORD_W'(y);
		it.in_blue  = b;
		it.in_green = g;
		it.in_red   = r;
		it.in_alpha = 8'($urandom);
		send_item(it);
	endtask

	// stop pushing and let every pending pixel and load drain
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// default registers: empty logo covers nothing, frame corners included
	task automatic test_reset_state();
		send_pixel(0, 0, 8'd0, 8'd0, 8'd0);
		send_pixel(COORD_MAX, COORD_MAX, 8'd255, 8'd255, 8'd255);
		send_pixel(COORD_MAX, 0, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// gray, bgr and unused mode replacement, rectangle edges
	task automatic test_replace_modes();
		settle();
		set_config(10, 5, 2, 2, 0, 0, 1'b0, MODE_GRAY);
		send_load(0, 0, 8'd255, 8'd0, 8'd17, 8'd0);
		send_load(1, 0, 8'd0, 8'd255, 8'd33, 8'd255);
		send_load(0, 1, 8'd128, 8'd64, 8'd255, 8'd128);
		send_load(1, 1, 8'd1, 8'd2, 8'd3, 8'd1);
		send_pixel(10, 5, 8'd9, 8'd9, 8'd9);
		send_pixel(11, 6, 8'd0, 8'd0, 8'd0);
		send_pixel(9, 5, 8'd200, 8'd100, 8'd50);
		send_pixel(12, 6, 8'd200, 8'd100, 8'd50);
		settle();
		write_reg(REG_CHANNEL_MODE, CFG_DATA_W'(MODE_BGR));
		send_pixel(11, 5, 8'd7, 8'd7, 8'd7);
		settle();
		write_reg(REG_CHANNEL_MODE, CFG_DATA_W'(MODE_UNUSED));
		send_pixel(10, 6, 8'd77, 8'd88, 8'd99);
	endtask

	// blend at zero, full and middle alpha with extreme colors
	task automatic test_blend_alpha();
		settle();
		write_reg(REG_CHANNEL_MODE, CFG_DATA_W'(MODE_BLEND));
		send_pixel(10, 5, 8'd255, 8'd255, 8'd255);
		send_pixel(11, 5, 8'd0, 8'd0, 8'd0);
		send_pixel(10, 6, 8'd0, 8'd255, 8'd0);
	endtask

	// loads outside the store are dropped; oversize logo clips to the store
	task automatic test_store_edges();
		settle();
		send_load(STORE_W, 0, 8'd11, 8'd22, 8'd33, 8'd44);
		send_load(0, STORE_H, 8'd11, 8'd22, 8'd33, 8'd44);
		send_load(COORD_MAX, COORD_MAX, 8'd11, 8'd22, 8'd33, 8'd44);
		send_load(STORE_W - 1, STORE_H - 1, 8'd250, 8'd251, 8'd252, 8'd253);
		settle();
		set_config(0, 0, SIZE_FIELD_MAX, SIZE_FIELD_MAX, 0, 0, 1'b0, MODE_BGR);
		send_pixel(STORE_W - 1, STORE_H - 1, 8'd1, 8'd1, 8'd1);
		send_pixel(STORE_W, 0, 8'd2, 8'd2, 8'd2);
		send_pixel(0, STORE_H, 8'd3, 8'd3, 8'd3);
	endtask

	// centering in a larger and a smaller box, position extremes, empty logo
	task automatic test_centering();
		settle();
		set_config(100, 100, 4, 4, 10, 7, 1'b1, MODE_BLEND);
		send_pixel(103, 101, 8'd40, 8'd50, 8'd60);
		send_pixel(102, 101, 8'd40, 8'd50, 8'd60);
		send_pixel(107, 101, 8'd40, 8'd50, 8'd60);
		settle();
		set_config(100, 100, 4, 4, 2, 2, 1'b1, MODE_GRAY);
		send_pixel(100, 100, 8'd5, 8'd6, 8'd7);
		settle();
		set_config(POS_MAX, POS_MAX, 2, 2, 0, 0, 1'b0, MODE_BGR);
		send_pixel(COORD_MAX, COORD_MAX, 8'd5, 8'd6, 8'd7);
		settle();
		set_config(POS_MIN, POS_MIN, 300, 0, COORD_MAX, COORD_MAX, 1'b1, MODE_BLEND);
		send_pixel(0, 0, 8'd5, 8'd6, 8'd7);
	endtask

	// phases of random registers; mostly pixels around the logo and logo loads
	task automatic test_random_stream();
		int ox, oy, lw, lh;
		int done;
		int r;
		int x, y;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			steady_flow = ($urandom_range(0, 3) == 0);
			set_config(pick_pos(), pick_pos(), pick_size(), pick_size(), pick_box(), pick_box(),
				1'($urandom), 2'($urandom));
			place_logo(ox, oy, lw, lh);
			done = 0;
			while (done < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					send_pixel(rand_near(ox, lw), rand_near(oy, lh),
						8'($urandom), 8'($urandom), 8'($urandom));
					done++;
				end else if (r < 85 && lw > 0 && lh > 0) begin
					send_load($urandom_range(0, lw - 1), $urandom_range(0, lh - 1),
						8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
					done++;
				end else begin
					// noise over the whole coordinate range
					x = $urandom_range(0, COORD_MAX);
					y = $urandom_range(0, COORD_MAX);
					if ($urandom_range(0, 1) == 1) begin
						send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
						done++;
					end else begin
						send_load(x, y, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
						if (x < STORE_W && y < STORE_H)
							done++;
					end
				end
			end
		end
		steady_flow = 1'b0;
	endtask

	// result side: random stalls on pop
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (!steady_flow && $urandom_range(0, 99) < 40)
					stall = gap_len();
			end
		end
	end

	// compare each result transaction with the oldest pending pixel
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				$error("result transaction with no pixel pending: %h", result);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_blue", want.out_blue, result.out_blue);
				check_field("out_green", want.out_green, result.out_green);
				check_field("out_red", want.out_red, result.out_red);
				check_field("covered", want.covered, result.covered);
			end
		end
	end

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_replace_modes();
		test_blend_alpha();
		test_store_edges();
		test_centering();
		test_random_stream();
		settle();
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
